FILE: design/sws_pkg.sv
// shared types and constants for the stack with search
`timescale 1ns / 1ps

package sws_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int POS_EXT_W = (IDX_W + 1 > POS_W) ? IDX_W + 1 : POS_W;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t            op;
    logic [WORD_W-1:0]   word;
  } cell_ctl_t;

endpackage

FILE: design/sws_cell.sv
// one stack cell: holds a word, shifts with its neighbors, compares with the target
`timescale 1ns / 1ps

module sws_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  sws_pkg::cell_ctl_t         ctl,
  input  logic [sws_pkg::WORD_W-1:0] word_up,
  input  logic                       valid_up,
  input  logic [sws_pkg::WORD_W-1:0] word_dn,
  input  logic                       valid_dn,
  output logic [sws_pkg::WORD_W-1:0] word,
  output logic                       valid,
  output logic                       hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        sws_pkg::OP_PUSH: valid <= valid_up;
        sws_pkg::OP_POP:  valid <= valid_dn;
        default:          valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      sws_pkg::OP_PUSH: word <= word_up;
      sws_pkg::OP_POP:  word <= word_dn;
      default:          word <= word;
    endcase
  end

  assign hit = valid && (word == ctl.word);

endmodule

FILE: design/sws_find.sv
// finds the topmost set hit bit and gives its position counted from 1
`timescale 1ns / 1ps

module sws_find (
  input  logic [sws_pkg::DEPTH-1:0] hits,
  output logic                      any,
  output logic [sws_pkg::POS_W-1:0] position
);

  logic [sws_pkg::DEPTH-1:0]     first;
  logic [sws_pkg::IDX_W-1:0]     idx;
  logic [sws_pkg::POS_EXT_W-1:0] pos_ext;

  // isolate the lowest set bit (cell 0 is the top)
  assign first = hits & (~hits + sws_pkg::DEPTH'(1));
  assign any   = |hits;

  always_comb begin
    idx = '0;
    for (int b = 0; b < sws_pkg::IDX_W; b++) begin
      for (int i = 0; i < sws_pkg::DEPTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          idx[b] = idx[b] | first[i];
        end
      end
    end
  end

  assign pos_ext  = sws_pkg::POS_EXT_W'(idx) + sws_pkg::POS_EXT_W'(1);
  assign position = pos_ext[sws_pkg::POS_W-1:0];

endmodule

FILE: design/stack_with_search.sv
// top level of the lifo stack of signed words with a search command
`timescale 1ns / 1ps

// stack of DEPTH signed 32-bit words built as a chain of cells, cell 0
// holding the top word. a word is taken when start is high and busy is low;
// cmd selects push, pop or search. every word taken gives exactly one result
// word on status, popped_value and position, marked by done for one cycle.
// the receiver cannot stall: the result must be taken in the cycle it shows.
// push and pop shift the whole chain by one cell at once and show their
// result in the cycle after the command is taken, so they run one per cycle
// while busy stays low. a search compares the target in every cell at once
// when taken, then the registered compare results pick the topmost match
// while busy is high for a single cycle. a search or pop on an empty stack,
// a push on a full one and the unused command code answer in the cycle after.
module stack_with_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic signed [sws_pkg::WORD_W-1:0] value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [sws_pkg::WORD_W-1:0] popped_value,
  output logic [sws_pkg::POS_W-1:0]         position
);

  localparam int D = sws_pkg::DEPTH;

  // chain of cells
  logic [sws_pkg::WORD_W-1:0] words [D];
  logic [D-1:0]               valids;
  logic [D-1:0]               hit_vec;
  sws_pkg::cell_ctl_t         ctl;

  // control and result registers
  logic [sws_pkg::CNT_W-1:0]  count;
  logic [sws_pkg::CNT_W-1:0]  count_next;
  logic                       pend;       // search waiting for its pick cycle
  logic [D-1:0]               hits;       // registered compare results
  sws_pkg::status_t           status_r;
  logic [sws_pkg::WORD_W-1:0] popped_r;
  logic [sws_pkg::POS_W-1:0]  position_r;

  logic                       accept;
  sws_pkg::cmd_t              cmd_c;
  logic                       is_empty;
  logic                       is_full;
  logic                       find_any;
  logic [sws_pkg::POS_W-1:0]  find_pos;

  assign accept   = start && !busy;
  assign cmd_c    = sws_pkg::cmd_t'(cmd);
  assign is_empty = (count == '0);
  assign is_full  = (count == sws_pkg::CNT_W'(D));
  assign busy     = pend;

  // chain shift control: a push on a non-full stack or a pop on a non-empty one moves every cell, else hold
  always_comb begin
    ctl.word = value;
    ctl.op   = sws_pkg::OP_HOLD;
    if (accept) begin
      case (cmd_c)
        sws_pkg::CMD_PUSH: if (!is_full)  ctl.op = sws_pkg::OP_PUSH;
        sws_pkg::CMD_POP:  if (!is_empty) ctl.op = sws_pkg::OP_POP;
        default:           ctl.op = sws_pkg::OP_HOLD;
      endcase
    end
  end

  always_comb begin
    count_next = count;
    case (ctl.op)
      sws_pkg::OP_PUSH: count_next = count + sws_pkg::CNT_W'(1);
      sws_pkg::OP_POP:  count_next = count - sws_pkg::CNT_W'(1);
      default:          count_next = count;
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic [sws_pkg::WORD_W-1:0] up_word;
    logic                       up_valid;
    logic [sws_pkg::WORD_W-1:0] dn_word;
    logic                       dn_valid;

    // the top cell takes the pushed word, the bottom cell empties on a pop
    if (i == 0) begin : g_top
      assign up_word  = value;
      assign up_valid = 1'b1;
    end else begin : g_mid_up
      assign up_word  = words[i-1];
      assign up_valid = valids[i-1];
    end

    if (i == D - 1) begin : g_bot
      assign dn_word  = '0;
      assign dn_valid = 1'b0;
    end else begin : g_mid_dn
      assign dn_word  = words[i+1];
      assign dn_valid = valids[i+1];
    end

    sws_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .word_up  (up_word),
      .valid_up (up_valid),
      .word_dn  (dn_word),
      .valid_dn (dn_valid),
      .word     (words[i]),
      .valid    (valids[i]),
      .hit      (hit_vec[i])
    );
  end

  // topmost match from the registered compare results
  sws_find u_find (
    .hits     (hits),
    .any      (find_any),
    .position (find_pos)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      pend  <= accept && (cmd_c == sws_pkg::CMD_SEARCH) && !is_empty;
      done  <= pend || (accept && !((cmd_c == sws_pkg::CMD_SEARCH) && !is_empty));
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    hits <= hit_vec;
    if (pend) begin
      status_r   <= find_any ? sws_pkg::ST_OK : sws_pkg::ST_NOT_FOUND;
      popped_r   <= '0;
      position_r <= find_any ? find_pos : '0;
    end else if (accept) begin
      popped_r   <= '0;
      position_r <= '0;
      case (cmd_c)
        sws_pkg::CMD_PUSH: begin
          status_r <= is_full ? sws_pkg::ST_FULL : sws_pkg::ST_OK;
        end
        sws_pkg::CMD_POP: begin
          status_r <= is_empty ? sws_pkg::ST_EMPTY : sws_pkg::ST_OK;
          popped_r <= is_empty ? '0 : words[0];
        end
        sws_pkg::CMD_SEARCH: begin
          status_r <= sws_pkg::ST_EMPTY;
        end
        default: begin
          status_r <= sws_pkg::ST_OK;
        end
      endcase
    end
  end

  assign status       = status_r;
  assign popped_value = popped_r;
  assign position     = position_r;

  // a search in its pick cycle shows no result yet
  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result shown while a search is being resolved");

  // every result follows a taken word or a search pick cycle
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command");

  // fill count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sws_pkg::CNT_W'(D))
    else $error("fill count beyond depth");

  // occupied cells form a solid run from the top matching the fill count
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    valids == ~({D{1'b1}} << count))
    else $error("cell valid bits disagree with fill count");

endmodule
